FILE: rtl/core/dsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants for the slot deque.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int SLOT_W = 10;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int OCC_W  = 11;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_slot;
    logic  wr_en;
    slot_t wr_slot;
    logic  wr_bit;
    logic  clear;
  } member_cmd_t;

endpackage : dsd_pkg
`default_nettype wire

FILE: rtl/core/dsd_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_ring_mem
// Ring store of slot numbers: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsd_ring_mem
  import dsd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int PW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [PW-1:0] rd_addr,
  output slot_t              rd_data,
  input  wire logic          wr_en,
  input  wire logic [PW-1:0] wr_addr,
  input  wire slot_t         wr_data
);

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : dsd_ring_mem
`default_nettype wire

FILE: rtl/core/dsd_member_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_member_map
// Membership bitmap, one bit per slot number, with a clearing sweep after
// reset and on request.
// ----------------------------------------------------------------------------
module dsd_member_map
  import dsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire member_cmd_t cmd,
  output logic             rd_bit,
  output logic             busy
);

  logic  mem [SLOTS];
  logic  rd_bit_r;
  logic  sweep_r, sweep_nxt;
  slot_t sweep_cnt_r, sweep_cnt_nxt;

  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      if (sweep_cnt_r == slot_t'(SLOTS - 1)) begin
        sweep_nxt = 1'b0;
      end
    end else if (cmd.clear) begin
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      mem[sweep_cnt_r] <= 1'b0;
    end else if (cmd.wr_en) begin
      mem[cmd.wr_slot] <= cmd.wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_bit_r <= mem[cmd.rd_slot];
    end
  end

  assign rd_bit = rd_bit_r;
  assign busy   = sweep_r;

endmodule : dsd_member_map
`default_nettype wire

FILE: rtl/core/dedup_slot_deque.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_slot_deque
// Ring deque of slot numbers that never holds the same slot twice.
// ----------------------------------------------------------------------------
// Each word is handled as a synchronous read of the membership bitmap and
// the ring store, then a decision, write back and load of the result
// register. The result register lets the next word be taken while a result
// waits. After reset, and after every clear, the membership bitmap is swept
// one entry a cycle and no word is accepted meanwhile; the clear's own
// result is delivered at the start of that sweep.
// ----------------------------------------------------------------------------
module dedup_slot_deque
  import dsd_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  input  wire logic [SLOT_W-1:0] in_slot_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [SLOT_W-1:0]     out_popped_slot,
  output logic [OCC_W-1:0]      out_occupancy
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  action_t         action_r, action_nxt;
  slot_t           slot_r, slot_nxt;
  logic [PW-1:0]   back_ptr_r, back_ptr_nxt;
  logic [PW-1:0]   front_ptr_r, front_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  slot_t           popped_r, popped_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  member_cmd_t     mcmd;
  logic            mm_bit;
  logic            mm_busy;
  logic            ring_rd_en;
  slot_t           ring_rd_data;
  logic            ring_wr_en;
  logic [PW-1:0]   ring_wr_addr;
  logic            in_fire;
  logic            exec_go;
  logic            deque_full;
  logic            slot_beyond;
  status_t         push_st;
  logic [PW-1:0]   front_prev;
  logic [PW-1:0]   front_next;
  logic [PW-1:0]   back_next;

  assign in_ready = (state_r == S_IDLE) && !mm_busy;
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign deque_full  = (fill_r == CW'(DEPTH));
  assign slot_beyond = (32'(slot_r) >= 32'(DEPTH));
  assign front_prev  = (front_ptr_r == '0) ? PW'(DEPTH - 1) : front_ptr_r - 1'b1;
  assign front_next  = (front_ptr_r == PW'(DEPTH - 1)) ? '0 : front_ptr_r + 1'b1;
  assign back_next   = (back_ptr_r == PW'(DEPTH - 1)) ? '0 : back_ptr_r + 1'b1;

  always_comb begin
    if (slot_beyond) begin
      push_st = ST_FULL;
    end else if (mm_bit) begin
      push_st = ST_QUEUED;
    end else if (deque_full) begin
      push_st = ST_FULL;
    end else begin
      push_st = ST_DONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    slot_nxt      = slot_r;
    back_ptr_nxt  = back_ptr_r;
    front_ptr_nxt = front_ptr_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    occ_nxt       = occ_r;
    mcmd          = '0;
    mcmd.rd_en    = in_fire;
    mcmd.rd_slot  = in_slot_in;
    ring_rd_en    = in_fire;
    ring_wr_en    = 1'b0;
    ring_wr_addr  = back_ptr_r;

    if (in_fire) begin
      action_nxt = action_t'(in_action);
      slot_nxt   = in_slot_in;
      state_nxt  = S_EXEC;
    end

    if (exec_go) begin
      state_nxt  = S_IDLE;
      status_nxt = ST_DONE;
      popped_nxt = '0;
      case (action_r)
        ACT_PUSH_BACK: begin
          status_nxt = push_st;
          if (push_st == ST_DONE) begin
            ring_wr_en   = 1'b1;
            ring_wr_addr = back_ptr_r;
            back_ptr_nxt = back_next;
            fill_nxt     = fill_r + 1'b1;
            mcmd.wr_en   = 1'b1;
            mcmd.wr_slot = slot_r;
            mcmd.wr_bit  = 1'b1;
          end
        end
        ACT_PUSH_FRONT: begin
          status_nxt = push_st;
          if (push_st == ST_DONE) begin
            ring_wr_en    = 1'b1;
            ring_wr_addr  = front_prev;
            front_ptr_nxt = front_prev;
            fill_nxt      = fill_r + 1'b1;
            mcmd.wr_en    = 1'b1;
            mcmd.wr_slot  = slot_r;
            mcmd.wr_bit   = 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (fill_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt    = ring_rd_data;
            front_ptr_nxt = front_next;
            fill_nxt      = fill_r - 1'b1;
            mcmd.wr_en    = 1'b1;
            mcmd.wr_slot  = ring_rd_data;
            mcmd.wr_bit   = 1'b0;
          end
        end
        default: begin
          fill_nxt      = '0;
          back_ptr_nxt  = '0;
          front_ptr_nxt = '0;
          mcmd.clear    = 1'b1;
        end
      endcase
      occ_nxt       = OCC_W'(fill_nxt);
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      back_ptr_r  <= '0;
      front_ptr_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      back_ptr_r  <= back_ptr_nxt;
      front_ptr_r <= front_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    occ_r    <= occ_nxt;
  end

  dsd_ring_mem #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ring (
    .clk     (clk),
    .rd_en   (ring_rd_en),
    .rd_addr (front_ptr_r),
    .rd_data (ring_rd_data),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (slot_r)
  );

  dsd_member_map u_member (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mcmd),
    .rd_bit (mm_bit),
    .busy   (mm_busy)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_popped_slot = popped_r;
  assign out_occupancy   = occ_r;

  // fill never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted word not executed");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_DONE) |-> (popped_r == '0))
    else $error("refused word carries a popped slot");

  a_sweep_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mm_busy) |-> $past(exec_go && (action_r == ACT_CLEAR)))
    else $error("bitmap sweep without a clear");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && (action_r == ACT_CLEAR) |=> (fill_r == '0) && (occ_r == '0))
    else $error("clear left entries");

endmodule : dedup_slot_deque
`default_nettype wire
